@@ rtl/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg
// Types and constants shared by the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QW          = 32;

  typedef struct packed {
    logic signed [QW-1:0] origin_x;
    logic signed [QW-1:0] origin_y;
    logic signed [QW-1:0] origin_z;
    logic signed [QW-1:0] dir_x;
    logic signed [QW-1:0] dir_y;
    logic signed [QW-1:0] dir_z;
    logic signed [QW-1:0] box_min_x;
    logic signed [QW-1:0] box_min_y;
    logic signed [QW-1:0] box_min_z;
    logic signed [QW-1:0] box_max_x;
    logic signed [QW-1:0] box_max_y;
    logic signed [QW-1:0] box_max_z;
  } rbsi_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [QW-1:0] distance;
  } rbsi_out_t;

endpackage

@@ rtl/ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of one ray against one axis-aligned box, signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat enters per cycle unless a stall reaches the
// input. Its path is the input stage, the per-axis reciprocal at four
// quotient bits per stage over 2*FRAC_BITS+1 bits (Q16.16 by default),
// then reciprocal clamp, multiply, saturate, reduction and output stages.
// Stalls ripple back only as far as the first empty stage, so bubbles are
// squeezed out.
module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rbsi_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rbsi_out_t out_data_o
);

  localparam int unsigned NQ = 2 * FRAC_BITS + 1;
  localparam int unsigned DB = 4;
  localparam int unsigned ND = (NQ + DB - 1) / DB;
  localparam int unsigned IR = ND + 1;
  localparam int unsigned IM = ND + 2;
  localparam int unsigned IS = ND + 3;
  localparam int unsigned IC = ND + 4;
  localparam int unsigned IO = ND + 5;
  localparam int unsigned NS = ND + 6;
  localparam int unsigned CW = (NQ > 33) ? NQ : 33;

  typedef struct packed {
    logic [32:0] lo_mag;
    logic [32:0] hi_mag;
    logic        lo_neg;
    logic        hi_neg;
    logic [31:0] dmag;
    logic        dneg;
    logic        dzero;
  } ax_t;

  typedef struct packed {
    logic [47:0] lo_pl;
    logic [48:0] lo_ph;
    logic [47:0] hi_pl;
    logic [48:0] hi_ph;
    logic        lo_neg;
    logic        hi_neg;
  } pp_t;

  function automatic logic [31:0] sat_mul(input logic [48:0] ph, input logic [47:0] pl,
                                          input logic neg);
    logic [64:0] mf;
    logic [64:0] m;
    logic [31:0] res;
    mf = {ph, 16'b0} + {17'b0, pl};
    m  = mf >> FRAC_BITS;
    if (neg) begin
      if (m > 65'h0_8000_0000) res = 32'h8000_0000;
      else res = 32'(0) - m[31:0];
    end else begin
      if (m > 65'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = m[31:0];
    end
    return res;
  endfunction

  logic [NS:0]   en;
  logic [NS-1:0] v_q;

  always_comb begin
    en[NS] = !out_stall_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // input stage: corner differences and direction magnitude
  ax_t            ax_q   [ND+1][3];
  logic [31:0]    rem_q  [ND+1][3];
  logic [NQ-1:0]  quo_q  [ND+1][3];
  ax_t            ax_d   [3];
  logic [QW-1:0]  org_w  [3];
  logic [QW-1:0]  dir_w  [3];
  logic [QW-1:0]  lo_w   [3];
  logic [QW-1:0]  hi_w   [3];

  assign org_w = '{in_data_i.origin_x, in_data_i.origin_y, in_data_i.origin_z};
  assign dir_w = '{in_data_i.dir_x, in_data_i.dir_y, in_data_i.dir_z};
  assign lo_w  = '{in_data_i.box_min_x, in_data_i.box_min_y, in_data_i.box_min_z};
  assign hi_w  = '{in_data_i.box_max_x, in_data_i.box_max_y, in_data_i.box_max_z};

  always_comb begin
    logic [32:0] dl;
    logic [32:0] dh;
    for (int a = 0; a < 3; a++) begin
      dl = {lo_w[a][31], lo_w[a]} - {org_w[a][31], org_w[a]};
      dh = {hi_w[a][31], hi_w[a]} - {org_w[a][31], org_w[a]};
      ax_d[a].lo_neg = dl[32];
      ax_d[a].hi_neg = dh[32];
      ax_d[a].lo_mag = dl[32] ? 33'(0) - dl : dl;
      ax_d[a].hi_mag = dh[32] ? 33'(0) - dh : dh;
      ax_d[a].dneg   = dir_w[a][31];
      ax_d[a].dmag   = dir_w[a][31] ? 32'(0) - dir_w[a] : dir_w[a];
      ax_d[a].dzero  = (dir_w[a] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        ax_q[0][a]  <= ax_d[a];
        rem_q[0][a] <= '0;
        quo_q[0][a] <= '0;
      end
    end
  end

  // restoring divider for 2^(2F) / |dir|, DB quotient bits per stage
  for (genvar s = 1; s <= ND; s++) begin : g_div
    logic [31:0]   rem_d [3];
    logic [NQ-1:0] quo_d [3];

    always_comb begin
      logic [31:0]   r;
      logic [NQ-1:0] q;
      logic [32:0]   rs;
      logic          ge;
      for (int a = 0; a < 3; a++) begin
        r = rem_q[s-1][a];
        q = quo_q[s-1][a];
        for (int k = 0; k < DB; k++) begin
          if ((s - 1) * DB + k < NQ) begin
            rs = {r, (((s - 1) * DB + k) == 0)};
            ge = (rs >= {1'b0, ax_q[s-1][a].dmag});
            if (ge) r = 32'(rs - {1'b0, ax_q[s-1][a].dmag});
            else r = rs[31:0];
            q = {q[NQ-2:0], ge};
          end
        end
        rem_d[a] = r;
        quo_d[a] = q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        for (int a = 0; a < 3; a++) begin
          ax_q[s][a]  <= ax_q[s-1][a];
          rem_q[s][a] <= rem_d[a];
          quo_q[s][a] <= quo_d[a];
        end
      end
    end
  end

  // reciprocal clamp
  ax_t         axr_q [3];
  logic [31:0] mr_q  [3];
  logic        rneg_q[3];

  always_ff @(posedge clk_i) begin
    logic [CW-1:0] qx;
    logic [CW-1:0] lim;
    if (en[IR]) begin
      for (int a = 0; a < 3; a++) begin
        qx  = CW'(quo_q[ND][a]);
        lim = ax_q[ND][a].dneg ? CW'(33'h0_8000_0000) : CW'(33'h0_7FFF_FFFF);
        axr_q[a] <= ax_q[ND][a];
        if (ax_q[ND][a].dzero) begin
          mr_q[a]   <= 32'h7FFF_FFFF;
          rneg_q[a] <= 1'b0;
        end else begin
          mr_q[a]   <= (qx > lim) ? lim[31:0] : qx[31:0];
          rneg_q[a] <= ax_q[ND][a].dneg;
        end
      end
    end
  end

  // partial products
  pp_t pp_q [3];

  always_ff @(posedge clk_i) begin
    if (en[IM]) begin
      for (int a = 0; a < 3; a++) begin
        pp_q[a].lo_pl  <= 48'(axr_q[a].lo_mag[15:0]) * 48'(mr_q[a]);
        pp_q[a].lo_ph  <= 49'(axr_q[a].lo_mag[32:16]) * 49'(mr_q[a]);
        pp_q[a].hi_pl  <= 48'(axr_q[a].hi_mag[15:0]) * 48'(mr_q[a]);
        pp_q[a].hi_ph  <= 49'(axr_q[a].hi_mag[32:16]) * 49'(mr_q[a]);
        pp_q[a].lo_neg <= axr_q[a].lo_neg ^ rneg_q[a];
        pp_q[a].hi_neg <= axr_q[a].hi_neg ^ rneg_q[a];
      end
    end
  end

  // saturate and order per axis
  logic signed [31:0] tn_q [3];
  logic signed [31:0] tf_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    if (en[IS]) begin
      for (int a = 0; a < 3; a++) begin
        t1 = sat_mul(pp_q[a].lo_ph, pp_q[a].lo_pl, pp_q[a].lo_neg);
        t2 = sat_mul(pp_q[a].hi_ph, pp_q[a].hi_pl, pp_q[a].hi_neg);
        tn_q[a] <= (t1 < t2) ? t1 : t2;
        tf_q[a] <= (t1 > t2) ? t1 : t2;
      end
    end
  end

  // entry and exit
  logic signed [31:0] entry_q;
  logic signed [31:0] exit_q;

  always_ff @(posedge clk_i) begin
    logic signed [31:0] en_v;
    logic signed [31:0] ex_v;
    if (en[IC]) begin
      en_v = tn_q[0];
      ex_v = tf_q[0];
      for (int a = 1; a < 3; a++) begin
        if (tn_q[a] > en_v) en_v = tn_q[a];
        if (tf_q[a] < ex_v) ex_v = tf_q[a];
      end
      entry_q <= en_v;
      exit_q  <= ex_v;
    end
  end

  // output register
  rbsi_out_t out_q;

  always_ff @(posedge clk_i) begin
    logic h;
    if (en[IO]) begin
      h = !(exit_q < 0 || entry_q > exit_q);
      out_q.hit      <= h;
      out_q.distance <= h ? entry_q : exit_q;
    end
  end

  assign out_valid_o = v_q[IO];
  assign out_data_o  = out_q;

  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_recip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[IM] |-> (mr_q[0] <= 32'h8000_0000 && mr_q[1] <= 32'h8000_0000 &&
                 mr_q[2] <= 32'h8000_0000))
    else $error("reciprocal magnitude out of range");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[IC] && en[IO] && exit_q >= 0 && entry_q <= exit_q |=> out_data_o.hit)
    else $error("hit flag does not follow entry and exit");

endmodule

@@ sim/ray_box_slab_intersect_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_test
// Checks the ray versus box slab test against a fixed-point predictor.
// Directed rays cover zero, extreme and reversed cases; random rays follow,
// with random gaps and stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_test;
  import rbsi_pkg::*;

  localparam int unsigned FB        = FracBitsDef;
  localparam int unsigned LATENCY   = (2 * FB + 4) / 4 + 5;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int          HOLD_LEN  = 300;
  localparam longint      QMAX      = 64'sd2147483647;
  localparam longint      QMIN      = -64'sd2147483648;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  rbsi_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  rbsi_out_t out_data_o;

  rbsi_out_t hit_expected_q[$];
  int        err_cnt = 0;
  int        idle_cycles;
  bit        hold_off;
  int        stall_mode;
  int        hold_cnt;

  ray_box_slab_intersect #(.FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic longint sat_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint slab_recip(longint d);
    longint one_sq;
    one_sq = 64'sd1 <<< (2 * FB);
    if (d == 0) return QMAX;
    return sat_q(one_sq / d);
  endfunction

  function automatic longint slab_mul(longint a, longint b);
    bit          neg;
    logic [63:0] ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = (ma * mb) >> FB;
    if (neg) return (m > 64'h8000_0000) ? QMIN : -$signed(m);
    return (m > 64'h7FFF_FFFF) ? QMAX : $signed(m);
  endfunction

  function automatic rbsi_out_t predict_slab(rbsi_in_t r);
    longint org[3], dir[3], lo[3], hi[3];
    longint rc, t1, t2, tn, tf, entry, exit_d;
    rbsi_out_t o;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    lo  = '{r.box_min_x, r.box_min_y, r.box_min_z};
    hi  = '{r.box_max_x, r.box_max_y, r.box_max_z};
    entry = 0;
    exit_d = 0;
    for (int a = 0; a < 3; a++) begin
      rc = slab_recip(dir[a]);
      t1 = slab_mul(lo[a] - org[a], rc);
      t2 = slab_mul(hi[a] - org[a], rc);
      tn = (t1 < t2) ? t1 : t2;
      tf = (t1 > t2) ? t1 : t2;
      if (a == 0) begin
        entry = tn;
        exit_d = tf;
      end else begin
        if (tn > entry) entry = tn;
        if (tf < exit_d) exit_d = tf;
      end
    end
    o.hit = !(exit_d < 0 || entry > exit_d);
    o.distance = o.hit ? entry[31:0] : exit_d[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    err_cnt++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_ray(rbsi_in_t r);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    hit_expected_q = {hit_expected_q, predict_slab(r)};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_gapped(rbsi_in_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    send_ray(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hit_expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 3) - 1;
    endcase
  endfunction

  function automatic rbsi_in_t rand_ray(bit wide);
    rbsi_in_t r;
    logic [31:0] v[12];
    for (int i = 0; i < 12; i++)
      v[i] = rand_q(wide ? $urandom_range(0, 3) : ($urandom_range(0, 9) < 8 ? 1 : 0));
    r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    // Ordered boxes most of the time, so hits are common.
    if (!wide && $urandom_range(0, 3) != 0) begin
      if (r.box_min_x > r.box_max_x) {r.box_min_x, r.box_max_x} = {r.box_max_x, r.box_min_x};
      if (r.box_min_y > r.box_max_y) {r.box_min_y, r.box_max_y} = {r.box_max_y, r.box_min_y};
      if (r.box_min_z > r.box_max_z) {r.box_min_z, r.box_max_z} = {r.box_max_z, r.box_min_z};
    end
    return r;
  endfunction

  function automatic rbsi_in_t mk_ray(logic [31:0] o, logic [31:0] d,
                                      logic [31:0] lo, logic [31:0] hi);
    return {o, o, o, d, d, d, lo, lo, lo, hi, hi, hi};
  endfunction

  task automatic test_directed();
    rbsi_in_t r;
    send_ray(mk_ray(0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000));
    send_ray(mk_ray(0, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000));
    send_ray(mk_ray(0, 0, 32'hFFFF_0000, 32'h0001_0000));
    send_ray(mk_ray(0, 0, 0, 0));
    send_ray(mk_ray(32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000));
    send_ray(mk_ray(0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
    send_ray(mk_ray(0, 32'h0001_0000, 0, 0));
    send_ray(mk_ray(0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002));
    send_ray(mk_ray(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk_ray(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_ray(mk_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ray(mk_ray(0, 32'h0000_0002, 32'hFFFF_FFFE, 32'h0000_0002));
    send_ray(mk_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ray(mk_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    r = mk_ray(0, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
    r.dir_y = 0;
    r.box_min_y = 32'hFFFF_0000;
    r.box_max_y = 32'h0001_0000;
    send_ray(r);
    r.origin_y = 32'h0002_0000;
    send_ray(r);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_gapped(rand_ray($urandom_range(0, 4) == 0));
    drain();
  endtask

  task automatic test_backpressure();
    hold_off <= 1'b1;
    repeat (40) send_ray(rand_ray(1'b0));
    hold_off <= 1'b0;
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
    end else begin
      if (hold_off && hold_cnt < HOLD_LEN) begin
        out_stall_i <= 1'b1;
      end else if (stall_mode > 0) begin
        out_stall_i <= 1'b1;
        stall_mode  <= stall_mode - 1;
      end else begin
        stall_mode  <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // long hold-off while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_cnt <= 0;
    else if (hold_off && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
    else if (!hold_off) hold_cnt <= 0;
  end

  always @(posedge clk_i) begin
    rbsi_out_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o.distance, 0);
      end else begin
        exp = hit_expected_q.pop_front();
        if (out_data_o.hit !== exp.hit)
          report_mismatch("hit", out_data_o.hit, exp.hit);
        if (out_data_o.distance !== exp.distance)
          report_mismatch("distance", out_data_o.distance, exp.distance);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    hold_off    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(400);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0 && hit_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
